/* hdl/rmj_pkg.sv */
// rmj_pkg: shared types and constants for the radar measurement jacobian
// depends on nothing; imported by every module of the block
`timescale 1ns / 1ps

package rmj_pkg;

  localparam int unsigned FRAC_BITS_DEF    = 16;
  localparam int unsigned SQRT_STEPS       = 32;
  localparam int unsigned QUOT_BITS        = 32;
  localparam int unsigned PADDR_W          = 3;
  localparam logic [15:0] MIN_RANGE_SQ_RST = 16'd7;
  localparam logic        REG_MIN_RANGE_SQ = 1'b0;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
  } in_t;

  typedef struct packed {
    logic signed [31:0] drange_dpx;
    logic signed [31:0] drange_dpy;
    logic signed [31:0] dbearing_dpx;
    logic signed [31:0] dbearing_dpy;
    logic signed [31:0] drate_dpx;
    logic signed [31:0] drate_dpy;
    logic signed [31:0] drate_dvx;
    logic signed [31:0] drate_dvy;
    logic               range_too_small;
  } out_t;

  // square root chain payload
  typedef struct packed {
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] c1;
    logic [31:0] apx;
    logic [31:0] apy;
    logic [63:0] xmag;
    logic [5:0]  neg;
    logic        too_near;
  } sq_t;

  // divider chain payload, lanes 0-1 over r, 2-3 over c1, 4-5 over c3
  typedef struct packed {
    logic                  too_near;
    logic [5:0]            neg;
    logic [5:0]            big;
    logic [31:0]           r;
    logic [63:0]           c1;
    logic [95:0]           c3;
    logic [1:0][31:0]      rem_r;
    logic [1:0][63:0]      rem_c1;
    logic [1:0][95:0]      rem_c3;
    logic [5:0][31:0]      lq;
  } div_t;

endpackage

/* hdl/rmj_front.sv */
// rmj_front: squares, cross product and range threshold test, two stages
// depends on rmj_pkg
`timescale 1ns / 1ps

module rmj_front import rmj_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] min_range_sq_i,
  input  logic        in_valid_i,
  input  in_t         in_data_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  output sq_t         out_data_o,
  input  logic        out_ready_i
);

  logic               s0_v_q;
  logic signed [31:0] s0_px_q, s0_py_q;
  logic [63:0]        s0_sqx_q, s0_sqy_q;
  logic signed [63:0] s0_a_q, s0_b_q;
  logic signed [63:0] mxx, myy, ma, mb;
  logic               rdy0, rdy1;

  logic               s1_v_q;
  sq_t                s1_q, s1_d;

  logic [63:0]             c1;
  logic [15+FRAC_BITS:0]   thr;
  logic signed [64:0]      dab;
  logic                    xneg, sx, sy;

  assign rdy1       = ~s1_v_q | out_ready_i;
  assign rdy0       = ~s0_v_q | rdy1;
  assign in_ready_o = rdy0;

  assign mxx = in_data_i.pos_x * in_data_i.pos_x;
  assign myy = in_data_i.pos_y * in_data_i.pos_y;
  assign ma  = in_data_i.vel_x * in_data_i.pos_y;
  assign mb  = in_data_i.vel_y * in_data_i.pos_x;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
      s1_v_q <= 1'b0;
    end else begin
      if (rdy0) begin
        s0_v_q <= in_valid_i;
      end
      if (rdy1) begin
        s1_v_q <= s0_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy0 && in_valid_i) begin
      s0_px_q  <= in_data_i.pos_x;
      s0_py_q  <= in_data_i.pos_y;
      s0_sqx_q <= mxx;
      s0_sqy_q <= myy;
      s0_a_q   <= ma;
      s0_b_q   <= mb;
    end
    if (rdy1 && s0_v_q) begin
      s1_q <= s1_d;
    end
  end

  assign c1   = s0_sqx_q + s0_sqy_q;
  assign thr  = {min_range_sq_i, {FRAC_BITS{1'b0}}};
  assign dab  = 65'(s0_a_q) - 65'(s0_b_q);
  assign xneg = s0_a_q < s0_b_q;
  assign sx   = s0_px_q[31];
  assign sy   = s0_py_q[31];

  always_comb begin
    s1_d.v     = c1;
    s1_d.res   = '0;
    s1_d.c1    = c1;
    s1_d.apx   = sx ? 32'(-s0_px_q) : 32'(s0_px_q);
    s1_d.apy   = sy ? 32'(-s0_py_q) : 32'(s0_py_q);
    s1_d.xmag  = xneg ? 64'(-dab) : 64'(dab);
    s1_d.neg[0] = sx;
    s1_d.neg[1] = sy;
    s1_d.neg[2] = ~sy & (s0_py_q != 32'sd0);
    s1_d.neg[3] = sx;
    s1_d.neg[4] = sy ^ xneg;
    s1_d.neg[5] = sx ^ ~xneg;
    s1_d.too_near = (c1 == 64'd0) || (c1 < 64'(thr));
  end

  assign out_valid_o = s1_v_q;
  assign out_data_o  = s1_q;

endmodule

/* hdl/rmj_sqrt_cell.sv */
// rmj_sqrt_cell: one bit of the integer square root of the squared range
// depends on rmj_pkg
`timescale 1ns / 1ps

module rmj_sqrt_cell import rmj_pkg::*; #(
  parameter int unsigned K = 0
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic v_i,
  input  sq_t  d_i,
  output logic rdy_o,
  output logic v_o,
  output sq_t  d_o,
  input  logic rdy_i
);

  localparam logic [63:0] BIT = 64'd1 << (62 - 2 * K);

  logic        v_q;
  sq_t         d_q, nxt;
  logic [64:0] sum;
  logic        ge;

  assign rdy_o = ~v_q | rdy_i;
  assign sum   = {1'b0, d_i.res} + {1'b0, BIT};
  assign ge    = {1'b0, d_i.v} >= sum;

  always_comb begin
    nxt = d_i;
    if (ge) begin
      nxt.v   = d_i.v - sum[63:0];
      nxt.res = (d_i.res >> 1) + BIT;
    end else begin
      nxt.res = d_i.res >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (rdy_o) begin
      v_q <= v_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_o && v_i) begin
      d_q <= nxt;
    end
  end

  assign v_o = v_q;
  assign d_o = d_q;

endmodule

/* hdl/rmj_prep.sv */
// rmj_prep: range cubed and numerators from split products, then divider setup
// depends on rmj_pkg
`timescale 1ns / 1ps

module rmj_prep import rmj_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic v_i,
  input  sq_t  d_i,
  output logic rdy_o,
  output logic v_o,
  output div_t d_o,
  input  logic rdy_i
);

  localparam int unsigned NRW = 32 + FRAC_BITS;
  localparam int unsigned NCW = 32 + 2 * FRAC_BITS;
  localparam int unsigned N3W = 96 + FRAC_BITS;

  typedef struct packed {
    logic [63:0] c1;
    logic [31:0] r;
    logic [31:0] apx;
    logic [31:0] apy;
    logic [5:0]  neg;
    logic        too_near;
    logic [63:0] pc0;
    logic [63:0] pc1;
    logic [63:0] py0;
    logic [63:0] py1;
    logic [63:0] px0;
    logic [63:0] px1;
  } pp_t;

  logic     p0_v_q, p1_v_q, rdy1;
  pp_t      p0_q, p0_d;
  div_t     p1_q, p1_d;

  logic [95:0]    c3, ny, nx;
  logic [NRW-1:0] n0, n1;
  logic [NCW-1:0] n2, n3;
  logic [N3W-1:0] n4, n5;
  logic [31:0]    h0, h1;
  logic [63:0]    h2, h3;
  logic [95:0]    h4, h5;

  assign rdy1  = ~p1_v_q | rdy_i;
  assign rdy_o = ~p0_v_q | rdy1;

  always_comb begin
    p0_d.c1       = d_i.c1;
    p0_d.r        = d_i.res[31:0];
    p0_d.apx      = d_i.apx;
    p0_d.apy      = d_i.apy;
    p0_d.neg      = d_i.neg;
    p0_d.too_near = d_i.too_near;
    p0_d.pc0      = d_i.c1[31:0] * d_i.res[31:0];
    p0_d.pc1      = d_i.c1[63:32] * d_i.res[31:0];
    p0_d.py0      = d_i.apy * d_i.xmag[31:0];
    p0_d.py1      = d_i.apy * d_i.xmag[63:32];
    p0_d.px0      = d_i.apx * d_i.xmag[31:0];
    p0_d.px1      = d_i.apx * d_i.xmag[63:32];
  end

  assign c3 = {32'd0, p0_q.pc0} + {p0_q.pc1, 32'd0};
  assign ny = {32'd0, p0_q.py0} + {p0_q.py1, 32'd0};
  assign nx = {32'd0, p0_q.px0} + {p0_q.px1, 32'd0};

  assign n0 = {p0_q.apx, {FRAC_BITS{1'b0}}};
  assign n1 = {p0_q.apy, {FRAC_BITS{1'b0}}};
  assign n2 = {p0_q.apy, {(2 * FRAC_BITS){1'b0}}};
  assign n3 = {p0_q.apx, {(2 * FRAC_BITS){1'b0}}};
  assign n4 = {ny, {FRAC_BITS{1'b0}}};
  assign n5 = {nx, {FRAC_BITS{1'b0}}};

  assign h0 = 32'(n0[NRW-1:32]);
  assign h1 = 32'(n1[NRW-1:32]);
  assign h2 = 64'(n2[NCW-1:32]);
  assign h3 = 64'(n3[NCW-1:32]);
  assign h4 = 96'(n4[N3W-1:32]);
  assign h5 = 96'(n5[N3W-1:32]);

  always_comb begin
    p1_d.too_near  = p0_q.too_near;
    p1_d.neg       = p0_q.neg;
    p1_d.r         = p0_q.r;
    p1_d.c1        = p0_q.c1;
    p1_d.c3        = c3;
    p1_d.big[0]    = h0 >= p0_q.r;
    p1_d.big[1]    = h1 >= p0_q.r;
    p1_d.big[2]    = h2 >= p0_q.c1;
    p1_d.big[3]    = h3 >= p0_q.c1;
    p1_d.big[4]    = h4 >= c3;
    p1_d.big[5]    = h5 >= c3;
    p1_d.rem_r[0]  = h0;
    p1_d.rem_r[1]  = h1;
    p1_d.rem_c1[0] = h2;
    p1_d.rem_c1[1] = h3;
    p1_d.rem_c3[0] = h4;
    p1_d.rem_c3[1] = h5;
    p1_d.lq[0]     = n0[31:0];
    p1_d.lq[1]     = n1[31:0];
    p1_d.lq[2]     = n2[31:0];
    p1_d.lq[3]     = n3[31:0];
    p1_d.lq[4]     = n4[31:0];
    p1_d.lq[5]     = n5[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_v_q <= 1'b0;
      p1_v_q <= 1'b0;
    end else begin
      if (rdy_o) begin
        p0_v_q <= v_i;
      end
      if (rdy1) begin
        p1_v_q <= p0_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_o && v_i) begin
      p0_q <= p0_d;
    end
    if (rdy1 && p0_v_q) begin
      p1_q <= p1_d;
    end
  end

  assign v_o = p1_v_q;
  assign d_o = p1_q;

endmodule

/* hdl/rmj_div_cell.sv */
// rmj_div_cell: one quotient bit of all six restoring divisions
// depends on rmj_pkg
`timescale 1ns / 1ps

module rmj_div_cell import rmj_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic v_i,
  input  div_t d_i,
  output logic rdy_o,
  output logic v_o,
  output div_t d_o,
  input  logic rdy_i
);

  logic        v_q;
  div_t        d_q, nxt;
  logic [32:0] tr [2];
  logic [64:0] tc [2];
  logic [96:0] t3 [2];
  logic [5:0]  ge;

  assign rdy_o = ~v_q | rdy_i;

  always_comb begin
    nxt = d_i;
    for (int i = 0; i < 2; i++) begin
      tr[i]     = {d_i.rem_r[i], d_i.lq[i][31]};
      tc[i]     = {d_i.rem_c1[i], d_i.lq[2+i][31]};
      t3[i]     = {d_i.rem_c3[i], d_i.lq[4+i][31]};
      ge[i]     = tr[i] >= {1'b0, d_i.r};
      ge[2+i]   = tc[i] >= {1'b0, d_i.c1};
      ge[4+i]   = t3[i] >= {1'b0, d_i.c3};
      nxt.rem_r[i]  = ge[i]   ? 32'(tr[i] - {1'b0, d_i.r})  : tr[i][31:0];
      nxt.rem_c1[i] = ge[2+i] ? 64'(tc[i] - {1'b0, d_i.c1}) : tc[i][63:0];
      nxt.rem_c3[i] = ge[4+i] ? 96'(t3[i] - {1'b0, d_i.c3}) : t3[i][95:0];
    end
    for (int k = 0; k < 6; k++) begin
      nxt.lq[k] = {d_i.lq[k][30:0], ge[k]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (rdy_o) begin
      v_q <= v_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_o && v_i) begin
      d_q <= nxt;
    end
  end

  assign v_o = v_q;
  assign d_o = d_q;

endmodule

/* hdl/rmj_out.sv */
// rmj_out: sign, saturation and small-range zeroing into the output register
// depends on rmj_pkg
`timescale 1ns / 1ps

module rmj_out import rmj_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic v_i,
  input  div_t d_i,
  output logic rdy_o,
  output logic out_valid_o,
  output out_t out_data_o,
  input  logic out_ready_i
);

  logic             v_q;
  out_t             d_q, nxt;
  logic [5:0][31:0] val;
  logic [31:0]      m [6];

  assign rdy_o = ~v_q | out_ready_i;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      m[k] = (d_i.big[k] || (d_i.lq[k] > 32'h8000_0000)) ? 32'h8000_0000 : d_i.lq[k];
      if (d_i.too_near) begin
        val[k] = '0;
      end else if (d_i.neg[k]) begin
        val[k] = -m[k];
      end else begin
        val[k] = m[k][31] ? 32'h7fff_ffff : m[k];
      end
    end
    nxt.drange_dpx      = val[0];
    nxt.drate_dvx       = val[0];
    nxt.drange_dpy      = val[1];
    nxt.drate_dvy       = val[1];
    nxt.dbearing_dpx    = val[2];
    nxt.dbearing_dpy    = val[3];
    nxt.drate_dpx       = val[4];
    nxt.drate_dpy       = val[5];
    nxt.range_too_small = d_i.too_near;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (rdy_o) begin
      v_q <= v_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_o && v_i) begin
      d_q <= nxt;
    end
  end

  assign out_valid_o = v_q;
  assign out_data_o  = d_q;

endmodule

/* hdl/radar_measurement_jacobian.sv */
// radar_measurement_jacobian: top level, register port and the cell chains
// depends on rmj_pkg, rmj_front, rmj_sqrt_cell, rmj_prep, rmj_div_cell, rmj_out
`timescale 1ns / 1ps

// Takes one state vector (px, py, vx, vy, signed fixed point) per beat and
// returns the eight nonzero entries of the radar measurement jacobian. It
// accepts a new beat every cycle through two front stages (squares, cross
// product, threshold), a chain of 32 square-root cells (one root bit each),
// two setup stages (split products for range cubed and the numerators), a
// chain of 32 divider cells (one quotient bit of all six divisions each) and
// the output register. Each stage holds or moves on its own, so bubbles close
// up when the output stalls. Register 0 at byte address 0 is min_range_sq
// (reset 7); the user writes it only while the block is idle (not enforced).

module radar_measurement_jacobian import rmj_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  input  in_t                in_data_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  output out_t               out_data_o,
  input  logic               out_ready_i
);

  logic [15:0] min_q;
  logic        reg_hit;

  sq_t  sq_d   [SQRT_STEPS+1];
  logic sq_v   [SQRT_STEPS+1];
  logic sq_rdy [SQRT_STEPS+1];
  div_t dv_d   [QUOT_BITS+1];
  logic dv_v   [QUOT_BITS+1];
  logic dv_rdy [QUOT_BITS+1];

  assign pready  = 1'b1;
  assign reg_hit = paddr[PADDR_W-1:2] == REG_MIN_RANGE_SQ;
  assign prdata  = reg_hit ? {16'd0, min_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= MIN_RANGE_SQ_RST;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      min_q <= pwdata[15:0];
    end
  end

  rmj_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i, .rst_ni,
    .min_range_sq_i (min_q),
    .in_valid_i, .in_data_i, .in_ready_o,
    .out_valid_o (sq_v[0]),
    .out_data_o  (sq_d[0]),
    .out_ready_i (sq_rdy[0])
  );

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    rmj_sqrt_cell #(.K(k)) u_cell (
      .clk_i, .rst_ni,
      .v_i   (sq_v[k]),
      .d_i   (sq_d[k]),
      .rdy_o (sq_rdy[k]),
      .v_o   (sq_v[k+1]),
      .d_o   (sq_d[k+1]),
      .rdy_i (sq_rdy[k+1])
    );
  end

  rmj_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
    .clk_i, .rst_ni,
    .v_i   (sq_v[SQRT_STEPS]),
    .d_i   (sq_d[SQRT_STEPS]),
    .rdy_o (sq_rdy[SQRT_STEPS]),
    .v_o   (dv_v[0]),
    .d_o   (dv_d[0]),
    .rdy_i (dv_rdy[0])
  );

  for (genvar k = 0; k < QUOT_BITS; k++) begin : g_div
    rmj_div_cell u_cell (
      .clk_i, .rst_ni,
      .v_i   (dv_v[k]),
      .d_i   (dv_d[k]),
      .rdy_o (dv_rdy[k]),
      .v_o   (dv_v[k+1]),
      .d_o   (dv_d[k+1]),
      .rdy_i (dv_rdy[k+1])
    );
  end

  rmj_out u_out (
    .clk_i, .rst_ni,
    .v_i   (dv_v[QUOT_BITS]),
    .d_i   (dv_d[QUOT_BITS]),
    .rdy_o (dv_rdy[QUOT_BITS]),
    .out_valid_o, .out_data_o, .out_ready_i
  );

endmodule

/* tb/sv/radar_measurement_jacobian_tb.sv */
// radar_measurement_jacobian_tb: self-checking bench for the radar jacobian block
// predicts every result from the accepted state beats and min_range_sq
// depends on rmj_pkg and radar_measurement_jacobian
`timescale 1ns / 1ps

module radar_measurement_jacobian_tb;
  import rmj_pkg::*;

  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned PHASE_ITEMS  = 300;

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid_i;
  in_t                in_data_i;
  logic               in_ready_o;
  logic               out_valid_o;
  out_t               out_data_o;
  logic               out_ready_i;

  in_t         state_q[$];
  out_t        jacobian_q[$];
  logic [15:0] min_range_sq;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned errors;
  int unsigned beats_in;
  int unsigned beats_out;
  int unsigned small_seen;
  int unsigned cycles;

  radar_measurement_jacobian uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o),
    .out_ready_i(out_ready_i)
  );

  function automatic logic [31:0] floor_root(logic [63:0] v);
    logic [31:0]  res;
    logic [31:0]  t;
    logic [127:0] sq;
    res = '0;
    for (int i = 31; i >= 0; i--) begin
      t  = res | (32'd1 << i);
      sq = 128'(t) * 128'(t);
      if (sq <= 128'(v)) res = t;
    end
    return res;
  endfunction

  function automatic logic [31:0] sat_quot(bit neg, logic [127:0] num, logic [127:0] den);
    logic [127:0] m;
    m = (den == 0) ? 128'h8000_0000 : num / den;
    if (m > 128'h8000_0000) m = 128'h8000_0000;
    if (neg) return 32'd0 - m[31:0];
    if (m > 128'h7fff_ffff) return 32'h7fff_ffff;
    return m[31:0];
  endfunction

  function automatic out_t predict_jacobian(in_t s, logic [15:0] thr);
    out_t         o;
    longint       px;
    longint       py;
    longint       a;
    longint       b;
    logic [63:0]  apx;
    logic [63:0]  apy;
    logic [63:0]  c1;
    logic [63:0]  xmag;
    logic [31:0]  r;
    logic [127:0] den3;
    bit           xneg;
    px  = longint'(s.pos_x);
    py  = longint'(s.pos_y);
    apx = (px < 0) ? -px : px;
    apy = (py < 0) ? -py : py;
    c1  = apx * apx + apy * apy;
    o   = '0;
    if (c1 == 0 || c1 < (64'(thr) << FRAC_BITS_DEF)) begin
      o.range_too_small = 1'b1;
      return o;
    end
    r    = floor_root(c1);
    den3 = 128'(c1) * 128'(r);
    o.drange_dpx   = sat_quot(px < 0, 128'(apx) << FRAC_BITS_DEF, 128'(r));
    o.drange_dpy   = sat_quot(py < 0, 128'(apy) << FRAC_BITS_DEF, 128'(r));
    o.drate_dvx    = o.drange_dpx;
    o.drate_dvy    = o.drange_dpy;
    o.dbearing_dpx = sat_quot(py > 0, 128'(apy) << (2 * FRAC_BITS_DEF), 128'(c1));
    o.dbearing_dpy = sat_quot(px < 0, 128'(apx) << (2 * FRAC_BITS_DEF), 128'(c1));
    a = longint'(s.vel_x) * py;
    b = longint'(s.vel_y) * px;
    xneg = (a < b);
    xmag = xneg ? 64'(b - a) : 64'(a - b);
    o.drate_dpx = sat_quot((py < 0) != xneg,
                           (128'(apy) * 128'(xmag)) << FRAC_BITS_DEF, den3);
    o.drate_dpy = sat_quot((px < 0) != !xneg,
                           (128'(apx) * 128'(xmag)) << FRAC_BITS_DEF, den3);
    return o;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return $signed($urandom) >>> $urandom_range(0, 31);
      2:       return $signed($urandom) >>> $urandom_range(10, 22);
      3:       return $signed($urandom) >>> $urandom_range(24, 31);
      4:       return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return $signed($urandom) >>> $urandom_range(14, 18);
    endcase
  endfunction

  task automatic push_state(logic [31:0] px, logic [31:0] py, logic [31:0] vx,
                            logic [31:0] vy);
    in_t s;
    s.pos_x = px;
    s.pos_y = py;
    s.vel_x = vx;
    s.vel_y = vy;
    state_q.insert(state_q.size(), s);
  endtask

  task automatic push_random(int unsigned n);
    for (int i = 0; i < n; i++)
      push_state(rand_coord(), rand_coord(), rand_coord(), rand_coord());
  endtask

  // sampled at the falling edge so the driver's updates have settled
  task automatic wait_idle();
    @(negedge clk_i);
    while (state_q.size() != 0 || in_valid_i || jacobian_q.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_min_range_sq(logic [15:0] v);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(4 * REG_MIN_RANGE_SQ);
    pwdata  <= 32'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    min_range_sq = v;
  endtask

  task automatic check_field(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      errors++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, e, a);
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // driver: accept on handshake, then present the next beat or idle
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        jacobian_q.insert(jacobian_q.size(), predict_jacobian(in_data_i, min_range_sq));
        beats_in++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (state_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_data_i  <= state_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    out_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      beats_out++;
      if (jacobian_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, actual %h", $time, out_data_o);
      end else begin
        e = jacobian_q.pop_front();
        small_seen += e.range_too_small;
        check_field("drange_dpx", e.drange_dpx, out_data_o.drange_dpx);
        check_field("drange_dpy", e.drange_dpy, out_data_o.drange_dpy);
        check_field("dbearing_dpx", e.dbearing_dpx, out_data_o.dbearing_dpx);
        check_field("dbearing_dpy", e.dbearing_dpy, out_data_o.dbearing_dpy);
        check_field("drate_dpx", e.drate_dpx, out_data_o.drate_dpx);
        check_field("drate_dpy", e.drate_dpy, out_data_o.drate_dpy);
        check_field("drate_dvx", e.drate_dvx, out_data_o.drate_dvx);
        check_field("drate_dvy", e.drate_dvy, out_data_o.drate_dvy);
        check_field("range_too_small", 32'(e.range_too_small),
                    32'(out_data_o.range_too_small));
      end
    end
  end

  initial begin
    int unsigned idle_mode[4][2];
    logic [15:0] thr_mode[4];
    idle_mode      = '{'{0, 0}, '{48, 0}, '{0, 48}, '{19, 19}};
    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    out_ready_i    = 1'b1;
    min_range_sq   = MIN_RANGE_SQ_RST;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    errors         = 0;
    beats_in       = 0;
    beats_out      = 0;
    small_seen     = 0;
    cycles         = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset threshold: zero state, around the threshold, extremes, saturation
    push_state(32'd0, 32'd0, 32'h7fff_ffff, 32'h8000_0000);
    push_state(32'd2, 32'd1, 32'd5, 32'd9);
    push_state(32'd424, 32'd0, 32'd1, 32'd1);
    push_state(32'd0, 32'd677, 32'hffff_0000, 32'd0);
    push_state(32'd677, 32'd0, 32'd0, 32'd65536);
    push_state(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    push_state(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    push_state(32'h7fff_ffff, 32'd0, 32'h8000_0000, 32'h7fff_ffff);
    push_state(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    push_state(32'hffff_ffff, 32'hffff_ffff, 32'h0001_0000, 32'hffff_0000);
    push_state(32'h0001_0000, 32'hffff_0000, 32'h0002_0000, 32'h0003_0000);
    push_state(32'hfffe_0000, 32'h0000_8000, 32'h8000_0000, 32'd1);
    wait_idle();

    // zero threshold: tiny ranges reach the dividers and saturate
    write_min_range_sq(16'd0);
    push_state(32'd1, 32'd0, 32'd0, 32'd0);
    push_state(32'd0, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    push_state(32'd1, 32'd1, 32'h8000_0000, 32'h7fff_ffff);
    push_state(32'hffff_ffff, 32'd3, 32'h7fff_ffff, 32'h7fff_ffff);
    push_state(32'd0, 32'd0, 32'd1, 32'd1);
    wait_idle();

    // top threshold: three states whose ranges all lie above it
    write_min_range_sq(16'hffff);
    push_state(32'h00ff_ff7f, 32'd0, 32'd1, 32'd2);
    push_state(32'h0100_0000, 32'd0, 32'd1, 32'd2);
    push_state(32'h8000_0000, 32'd0, 32'd1, 32'd2);
    wait_idle();

    thr_mode = '{16'd7, 16'd0, 16'hffff, 16'($urandom)};
    for (int p = 0; p < 4; p++) begin
      write_min_range_sq(thr_mode[p]);
      send_idle_pct  = idle_mode[p][0];
      recv_stall_pct = idle_mode[p][1];
      push_random(PHASE_ITEMS / 2);
      // stretch with no idling inside each phase
      while (state_q.size() != 0) @(posedge clk_i);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      push_random(PHASE_ITEMS / 6);
      while (state_q.size() != 0) @(posedge clk_i);
      send_idle_pct  = idle_mode[p][0];
      recv_stall_pct = idle_mode[p][1];
      push_random(PHASE_ITEMS - PHASE_ITEMS / 2 - PHASE_ITEMS / 6);
      wait_idle();
    end

    $display("%0d state beats in, %0d jacobian beats out, %0d with range too small",
             beats_in, beats_out, small_seen);
    $display("covered thresholds 0, 7, 65535 and random under four idle/stall mixes");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/rmj_pkg.sv
hdl/rmj_front.sv
hdl/rmj_sqrt_cell.sv
hdl/rmj_prep.sv
hdl/rmj_div_cell.sv
hdl/rmj_out.sv
hdl/radar_measurement_jacobian.sv
tb/sv/radar_measurement_jacobian_tb.sv
